// ----- hw/rtl/atfb_pkg.sv -----
// Shared constants for the transmit-request frame builder.
package atfb_pkg;

  // Frame constants.
  localparam logic [7:0] SOF_BYTE    = 8'h7E;
  localparam logic [7:0] LEN_HI_BYTE = 8'h00;
  localparam logic [7:0] API_ID_BYTE = 8'h10;
  localparam logic [7:0] LEN_OFFSET  = 8'd14;
  localparam logic [7:0] MAX_PAYLOAD = 8'd241;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_DEST_ADDRESS = 3'd0;
  localparam logic [2:0] REG_DEST_NETWORK = 3'd1;
  localparam logic [2:0] REG_FRAME_IDENT  = 3'd2;
  localparam logic [2:0] REG_HOP_RADIUS   = 3'd3;
  localparam logic [2:0] REG_SEND_OPTIONS = 3'd4;

  // Byte positions of the sequencer.
  localparam logic [4:0] ST_SOF      = 5'd0;
  localparam logic [4:0] ST_LEN_HI   = 5'd1;
  localparam logic [4:0] ST_LEN_LO   = 5'd2;
  localparam logic [4:0] ST_API_ID   = 5'd3;
  localparam logic [4:0] ST_FRAME_ID = 5'd4;
  localparam logic [4:0] ST_ADDR7    = 5'd5;
  localparam logic [4:0] ST_ADDR6    = 5'd6;
  localparam logic [4:0] ST_ADDR5    = 5'd7;
  localparam logic [4:0] ST_ADDR4    = 5'd8;
  localparam logic [4:0] ST_ADDR3    = 5'd9;
  localparam logic [4:0] ST_ADDR2    = 5'd10;
  localparam logic [4:0] ST_ADDR1    = 5'd11;
  localparam logic [4:0] ST_ADDR0    = 5'd12;
  localparam logic [4:0] ST_NET_HI   = 5'd13;
  localparam logic [4:0] ST_NET_LO   = 5'd14;
  localparam logic [4:0] ST_RADIUS   = 5'd15;
  localparam logic [4:0] ST_OPTIONS  = 5'd16;
  localparam logic [4:0] ST_DATA     = 5'd17;
  localparam logic [4:0] ST_CHECK    = 5'd18;

endpackage

// ----- hw/rtl/api_transmit_frame_builder_unit.sv -----
// Top level of the transmit-request frame builder: item register, byte sequencer, output register.
// The first byte of a request is taken into the item register and leaves through the output register.
// A payload byte request yields one byte, a frame-opening request 18 or 19 bytes and a closing
// request two; the output register sends one byte per cycle while the receiver does not stall.
// Requests with no frame open are dropped without any result.
// Reset (synchronous, rst high) closes any frame, empties both registers and loads the
// configuration reset values (network address 0xFFFE, all others zero).
module api_transmit_frame_builder_unit
  import atfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        frame_start,
  input  logic [7:0]  payload_length,
  // Output channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        frame_end,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [63:0] dest_address;
  logic [15:0] dest_network;
  logic [7:0]  frame_ident;
  logic [7:0]  hop_radius;
  logic [7:0]  send_options;

  // Item register.
  logic        item_valid;
  logic [7:0]  item_data;
  logic [7:0]  item_len;
  logic [4:0]  step;

  // Frame state.
  logic [7:0]  sum_acc;
  logic [7:0]  bytes_left;
  logic        frame_open;

  // Sequencer outputs.
  logic [7:0]  gen_byte;
  logic        gen_last;
  logic        gen_check;
  logic        gen_drop;
  logic [4:0]  step_next;
  logic [7:0]  sum_next;
  logic [7:0]  bytes_left_next;
  logic        frame_open_next;
  logic        out_free;
  logic        emit;
  logic        done;
  logic        in_accept;
  logic [7:0]  len_clamped;
  logic [2:0]  reg_index;

  assign reg_index = paddr[5:3];
  assign pready    = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_address <= '0;
      dest_network <= 16'hFFFE;
      frame_ident  <= '0;
      hop_radius   <= '0;
      send_options <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_index)
        REG_DEST_ADDRESS: dest_address <= pwdata;
        REG_DEST_NETWORK: dest_network <= pwdata[15:0];
        REG_FRAME_IDENT:  frame_ident  <= pwdata[7:0];
        REG_HOP_RADIUS:   hop_radius   <= pwdata[7:0];
        REG_SEND_OPTIONS: send_options <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_index)
      REG_DEST_ADDRESS: prdata = dest_address;
      REG_DEST_NETWORK: prdata = {48'd0, dest_network};
      REG_FRAME_IDENT:  prdata = {56'd0, frame_ident};
      REG_HOP_RADIUS:   prdata = {56'd0, hop_radius};
      REG_SEND_OPTIONS: prdata = {56'd0, send_options};
      default:          prdata = '0;
    endcase
  end

  // One byte of the current request per cycle unless the output stalls, with its effect on the frame state.
  always_comb begin
    gen_byte        = '0;
    gen_last        = 1'b0;
    gen_check       = 1'b0;
    gen_drop        = 1'b0;
    step_next       = step + 5'd1;
    sum_next        = sum_acc + gen_byte;
    bytes_left_next = bytes_left;
    frame_open_next = frame_open;
    unique case (step)
      ST_SOF:      gen_byte = SOF_BYTE;
      ST_LEN_HI:   gen_byte = LEN_HI_BYTE;
      ST_LEN_LO:   gen_byte = item_len + LEN_OFFSET;
      ST_API_ID:   gen_byte = API_ID_BYTE;
      ST_FRAME_ID: gen_byte = frame_ident;
      ST_ADDR7:    gen_byte = dest_address[63:56];
      ST_ADDR6:    gen_byte = dest_address[55:48];
      ST_ADDR5:    gen_byte = dest_address[47:40];
      ST_ADDR4:    gen_byte = dest_address[39:32];
      ST_ADDR3:    gen_byte = dest_address[31:24];
      ST_ADDR2:    gen_byte = dest_address[23:16];
      ST_ADDR1:    gen_byte = dest_address[15:8];
      ST_ADDR0:    gen_byte = dest_address[7:0];
      ST_NET_HI:   gen_byte = dest_network[15:8];
      ST_NET_LO:   gen_byte = dest_network[7:0];
      ST_RADIUS:   gen_byte = hop_radius;
      ST_OPTIONS: begin
        gen_byte = send_options;
        // The header is complete: open the frame or go straight to the checksum.
        if (item_len == 8'd0) begin
          step_next = ST_CHECK;
        end else begin
          frame_open_next = 1'b1;
          bytes_left_next = item_len;
        end
      end
      ST_DATA: begin
        gen_byte = item_data;
        if (!frame_open || bytes_left == 8'd0) begin
          gen_drop = 1'b1;
        end else begin
          bytes_left_next = bytes_left - 8'd1;
          if (bytes_left == 8'd1) begin
            step_next = ST_CHECK;
          end else begin
            gen_last = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        gen_byte        = ~sum_acc;
        gen_check       = 1'b1;
        gen_last        = 1'b1;
        frame_open_next = 1'b0;
        bytes_left_next = '0;
      end
      default: gen_drop = 1'b1;
    endcase
    // The running sum restarts at the API identifier and skips the checksum itself.
    if (step == ST_API_ID) begin
      sum_next = API_ID_BYTE;
    end else if (step > ST_API_ID && step < ST_CHECK) begin
      sum_next = sum_acc + gen_byte;
    end else begin
      sum_next = sum_acc;
    end
  end

  // Handshake between the item register and the output register.
  assign out_free    = !out_valid || !out_stall;
  assign emit        = item_valid && !gen_drop && out_free;
  assign done        = item_valid && (gen_drop || (out_free && gen_last));
  assign in_stall    = item_valid && !done;
  assign in_accept   = in_valid && !in_stall;
  assign len_clamped = (payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD : payload_length;

  // Item register and frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      step       <= ST_SOF;
      sum_acc    <= '0;
      bytes_left <= '0;
      frame_open <= 1'b0;
    end else begin
      if (emit) begin
        sum_acc    <= sum_next;
        bytes_left <= bytes_left_next;
        frame_open <= frame_open_next;
      end
      if (in_accept) begin
        item_valid <= 1'b1;
        step       <= frame_start ? ST_SOF : ST_DATA;
      end else if (done) begin
        item_valid <= 1'b0;
      end else if (emit) begin
        step <= step_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_data <= data_byte;
      item_len  <= len_clamped;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte  <= gen_byte;
      run_last  <= gen_last;
      frame_end <= gen_check;
    end
  end

  // The input side only waits on a request that is still being worked on.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item_valid)
    else $error("input stalled with an empty item register");

  // The checksum always closes the request that caused it.
  a_check_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> run_last)
    else $error("checksum byte not marked as last result");

  // A closed frame never expects payload bytes.
  a_closed_frame_empty: assert property (@(posedge clk) disable iff (rst)
    !frame_open |-> (bytes_left == 8'd0))
    else $error("payload count left over with no frame open");

  // The sequencer never runs past the checksum position.
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    item_valid |-> (step <= ST_CHECK))
    else $error("sequencer step out of range");

  // A request that opens a frame keeps the input side waiting while the header goes out.
  a_header_holds_input: assert property (@(posedge clk) disable iff (rst)
    (item_valid && step < ST_OPTIONS) |-> in_stall)
    else $error("input taken in the middle of a header");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the transmit-request frame builder.
module tb_top;
  import atfb_pkg::*;

  // One byte of the serial frame as it leaves the block.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } frame_byte_t;

  // Kinds of rows in the directed stimulus plan.
  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_CFG_ONES,
    ROW_CFG_ZERO,
    ROW_CFG_RAND
  } row_kind_e;

  // One directed row; the checksum is typed in only where pinned is set.
  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] data;
    logic       start;
    logic [7:0] len;
    logic       pinned;
    logic [7:0] check;
  } plan_row_t;

  localparam int DRAIN_CYCLES = 4;
  localparam int USEFUL_ITEMS = 450;
  localparam int PLAN_ROWS    = 23;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        frame_start = 1'b0;
  logic [7:0]  payload_length = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        run_last;
  logic        frame_end;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = 6'd0;
  logic [63:0] pwdata = 64'd0;
  logic [63:0] prdata;
  logic        pready;

  // Shadow copy of the configuration registers.
  logic [63:0] cfg_dest_address;
  logic [15:0] cfg_dest_network;
  logic [7:0]  cfg_frame_ident;
  logic [7:0]  cfg_hop_radius;
  logic [7:0]  cfg_send_options;

  // Shadow copy of the framing state.
  logic [7:0]  pred_sum;
  logic [7:0]  pred_left;
  logic        pred_open;

  frame_byte_t frame_bytes_q[$];
  int          err_count = 0;
  int          useful_items = 0;
  int          cyc = 0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_ITEM,     8'h55, 1'b0, 8'h00, 1'b1, 8'h00},
    '{ROW_ITEM,     8'hAA, 1'b1, 8'h00, 1'b1, 8'hF2},
    '{ROW_ITEM,     8'hFF, 1'b1, 8'h01, 1'b1, 8'hF3},
    '{ROW_ITEM,     8'h00, 1'b1, 8'h01, 1'b1, 8'hF2},
    '{ROW_ITEM,     8'h12, 1'b0, 8'hFF, 1'b1, 8'h00},
    '{ROW_CFG_ONES, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
    '{ROW_ITEM,     8'h5A, 1'b1, 8'h00, 1'b1, 8'hFC},
    '{ROW_ITEM,     8'h80, 1'b1, 8'h02, 1'b0, 8'h00},
    '{ROW_ITEM,     8'h7F, 1'b0, 8'h00, 1'b0, 8'h00},
    '{ROW_ITEM,     8'h01, 1'b1, 8'hFF, 1'b0, 8'h00},
    '{ROW_ITEM,     8'h02, 1'b0, 8'h00, 1'b0, 8'h00},
    '{ROW_ITEM,     8'h03, 1'b1, 8'hF2, 1'b0, 8'h00},
    '{ROW_ITEM,     8'hFE, 1'b0, 8'h00, 1'b0, 8'h00},
    '{ROW_ITEM,     8'h04, 1'b1, 8'h03, 1'b0, 8'h00},
    '{ROW_ITEM,     8'h05, 1'b0, 8'hFF, 1'b0, 8'h00},
    '{ROW_ITEM,     8'h06, 1'b0, 8'h00, 1'b0, 8'h00},
    '{ROW_CFG_ZERO, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
    '{ROW_ITEM,     8'h33, 1'b1, 8'h00, 1'b1, 8'hEF},
    '{ROW_ITEM,     8'hAB, 1'b1, 8'h01, 1'b0, 8'h00},
    '{ROW_CFG_RAND, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
    '{ROW_ITEM,     8'h3C, 1'b1, 8'h02, 1'b0, 8'h00},
    '{ROW_ITEM,     8'hC3, 1'b1, 8'h01, 1'b0, 8'h00},
    '{ROW_ITEM,     8'h99, 1'b0, 8'h00, 1'b0, 8'h00}
  };

  api_transmit_frame_builder_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .frame_start    (frame_start),
    .payload_length (payload_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .run_last       (run_last),
    .frame_end      (frame_end),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #2 clk = ~clk;

  // A window of cycles in which neither side idles.
  function automatic logic quiet_window();
    return (cyc >= 500) && (cyc < 1100);
  endfunction

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // The receiver stalls at random outside the quiet window.
  always @(posedge clk) begin
    out_stall <= !rst && !quiet_window() && ($urandom_range(99) < 16);
  end

  // Appends one frame byte to the expected results and keeps the running sum.
  function automatic void emit_byte(input logic [7:0] b, input logic summed,
                                    input logic is_check);
    frame_byte_t fb;
    fb.out_byte  = b;
    fb.run_last  = 1'b0;
    fb.frame_end = is_check;
    frame_bytes_q.push_back(fb);
    if (summed) pred_sum = pred_sum + b;
  endfunction

  function automatic void emit_checksum();
    pred_open = 1'b0;
    pred_left = 8'd0;
    emit_byte(8'hFF - pred_sum, 1'b0, 1'b1);
  endfunction

  // Works out the bytes that one accepted request causes; returns their count.
  function automatic int build_frame_bytes(input logic [7:0] d, input logic s,
                                           input logic [7:0] l);
    int          start_size;
    logic [7:0]  len;
    frame_byte_t fb;
    start_size = frame_bytes_q.size();
    if (s) begin
      len = (l > MAX_PAYLOAD) ? MAX_PAYLOAD : l;
      emit_byte(SOF_BYTE, 1'b0, 1'b0);
      emit_byte(LEN_HI_BYTE, 1'b0, 1'b0);
      emit_byte(len + LEN_OFFSET, 1'b0, 1'b0);
      pred_sum = 8'd0;
      emit_byte(API_ID_BYTE, 1'b1, 1'b0);
      emit_byte(cfg_frame_ident, 1'b1, 1'b0);
      for (int i = 7; i >= 0; i--) begin
        emit_byte(cfg_dest_address[8*i +: 8], 1'b1, 1'b0);
      end
      emit_byte(cfg_dest_network[15:8], 1'b1, 1'b0);
      emit_byte(cfg_dest_network[7:0], 1'b1, 1'b0);
      emit_byte(cfg_hop_radius, 1'b1, 1'b0);
      emit_byte(cfg_send_options, 1'b1, 1'b0);
      if (len == 8'd0) begin
        emit_checksum();
      end else begin
        pred_open = 1'b1;
        pred_left = len;
      end
    end
    if (pred_open && pred_left != 8'd0) begin
      emit_byte(d, 1'b1, 1'b0);
      pred_left = pred_left - 8'd1;
      if (pred_left == 8'd0) emit_checksum();
    end
    if (frame_bytes_q.size() > start_size) begin
      fb = frame_bytes_q.pop_back();
      fb.run_last = 1'b1;
      frame_bytes_q.push_back(fb);
    end
    return frame_bytes_q.size() - start_size;
  endfunction

  // Offers one request, waits until it is taken, then predicts its bytes.
  task automatic send_item(input logic [7:0] d, input logic s, input logic [7:0] l,
                           output int n);
    while (!quiet_window() && ($urandom_range(99) < 16)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    data_byte      <= d;
    frame_start    <= s;
    payload_length <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = build_frame_bytes(d, s, l);
    if (n > 0) useful_items++;
  endtask

  // Holds the sender until every expected byte has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_bytes_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One write on the configuration port: setup cycle, then access cycle.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DEST_ADDRESS: cfg_dest_address = value;
      REG_DEST_NETWORK: cfg_dest_network = value[15:0];
      REG_FRAME_IDENT:  cfg_frame_ident  = value[7:0];
      REG_HOP_RADIUS:   cfg_hop_radius   = value[7:0];
      REG_SEND_OPTIONS: cfg_send_options = value[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Random register value that often lands on an extreme.
  function automatic logic [63:0] pick_reg_value();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 64'd0;
    if (r < 30) return {64{1'b1}};
    return {$urandom, $urandom};
  endfunction

  // Writes all five registers with one preset.
  task automatic load_config(input row_kind_e kind);
    logic [63:0] v [5];
    for (int i = 0; i < 5; i++) begin
      case (kind)
        ROW_CFG_ONES: v[i] = {64{1'b1}};
        ROW_CFG_ZERO: v[i] = 64'd0;
        default:      v[i] = pick_reg_value();
      endcase
    end
    write_reg(REG_DEST_ADDRESS, v[0]);
    write_reg(REG_DEST_NETWORK, {48'd0, v[1][15:0]});
    write_reg(REG_FRAME_IDENT,  {56'd0, v[2][7:0]});
    write_reg(REG_HOP_RADIUS,   {56'd0, v[3][7:0]});
    write_reg(REG_SEND_OPTIONS, {56'd0, v[4][7:0]});
  endtask

  // Payload length for a random frame: mostly short, sometimes at or past the limit.
  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 6) return 8'd0;
    if (r < 8) return ($urandom_range(1) == 0) ? MAX_PAYLOAD : 8'($urandom_range(255, 242));
    if (r < 25) return 8'($urandom_range(40, 9));
    return 8'($urandom_range(8, 1));
  endfunction

  // Compares every accepted output byte with the oldest expectation.
  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst && out_valid && !out_stall) begin
      if (frame_bytes_q.size() == 0) begin
        $error("unexpected byte: out_byte %h run_last %b frame_end %b",
               out_byte, run_last, frame_end);
        err_count++;
      end else begin
        want = frame_bytes_q.pop_front();
        if (out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, actual %h", want.out_byte, out_byte);
          err_count++;
        end
        if (run_last !== want.run_last) begin
          $error("run_last: expected %b, actual %b", want.run_last, run_last);
          err_count++;
        end
        if (frame_end !== want.frame_end) begin
          $error("frame_end: expected %b, actual %b", want.frame_end, frame_end);
          err_count++;
        end
      end
    end
  end

  // Stimulus: directed plan, then random frames with noise and abandoned frames.
  initial begin
    int          n;
    int          frame_no;
    int          cut;
    logic [7:0]  len;
    logic [7:0]  eff;
    frame_byte_t fb;

    cfg_dest_address = 64'd0;
    cfg_dest_network = 16'hFFFE;
    cfg_frame_ident  = 8'd0;
    cfg_hop_radius   = 8'd0;
    cfg_send_options = 8'd0;
    pred_sum  = 8'd0;
    pred_left = 8'd0;
    pred_open = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows; pinned rows carry a checksum read straight off the spec.
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].kind != ROW_ITEM) begin
        wait_drained();
        load_config(plan[r].kind);
      end else begin
        send_item(plan[r].data, plan[r].start, plan[r].len, n);
        if (plan[r].pinned && n > 0) begin
          fb = frame_bytes_q.pop_back();
          fb.out_byte = plan[r].check;
          frame_bytes_q.push_back(fb);
        end
      end
    end

    // Random frames until enough requests have produced output.
    useful_items = 0;
    frame_no = 0;
    while (useful_items < USEFUL_ITEMS) begin
      if (frame_no % 12 == 11) begin
        wait_drained();
        load_config(ROW_CFG_RAND);
      end
      if ($urandom_range(99) < 8) begin
        // Stray data; dropped unless an abandoned frame is still open.
        repeat ($urandom_range(3, 1)) begin
          send_item(8'($urandom), 1'b0, 8'($urandom), n);
        end
      end else begin
        len = pick_length();
        eff = (len > MAX_PAYLOAD) ? MAX_PAYLOAD : len;
        send_item(8'($urandom), 1'b1, len, n);
        cut = ($urandom_range(99) < 10) ? $urandom_range(eff) : eff;
        for (int k = 1; k < cut; k++) begin
          send_item(8'($urandom), 1'b0, 8'($urandom), n);
        end
        if ($urandom_range(99) < 4) wait_drained();
      end
      frame_no++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (err_count == 0 && frame_bytes_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog for a block that hangs.
  initial begin
    #2000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
